>>> rtl/pval_pkg.sv
// ----------------------------------------------------------------------------
// pval_pkg
// Shared constants and helpers for the position/velocity/acceleration limiter.
// ----------------------------------------------------------------------------
package pval_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [63:0] NS_PER_S     = 64'd1000000000;
  localparam logic [63:0] NS_PER_2S    = 64'd2000000000;
  localparam logic [63:0] NS_PER_QS    = 64'd250000000;
  localparam logic [63:0] SAT_LIM      = 64'h4000_0000_0000_0000;

  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (31 + FRAC_BITS)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -(64'sd1 <<< (31 + FRAC_BITS));
  localparam logic signed [63:0] ONE_M1  = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  // Register indexes
  localparam logic [2:0] REG_TICK   = 3'd0;
  localparam logic [2:0] REG_TMIN   = 3'd1;
  localparam logic [2:0] REG_TMAX   = 3'd2;
  localparam logic [2:0] REG_VLIM   = 3'd3;
  localparam logic [2:0] REG_ALIM   = 3'd4;

  // Saturate a wide signed value to +-2^62
  function automatic logic signed [63:0] sat64(input logic signed [65:0] x);
    logic signed [65:0] lim;
    lim = 66'(SAT_LIM);
    if (x > lim) begin
      sat64 = $signed(SAT_LIM);
    end else if (x < -lim) begin
      sat64 = -$signed(SAT_LIM);
    end else begin
      sat64 = x[63:0];
    end
  endfunction

endpackage

>>> rtl/position_velocity_accel_limiter.sv
// ----------------------------------------------------------------------------
// position_velocity_accel_limiter
// Second-order command shaper: clamps a position command to travel limits and
// follows it under velocity and acceleration limits, in Q.16 fixed point.
// ----------------------------------------------------------------------------
// Work: five product-quotients when the command is followed, seven when the
//   block ramps, each in turn on the one shared multiply/divide unit.
// Input: in_tready is high only when idle, so no new command is taken while
//   the last one is still being worked on.
// Reset: rst_n synchronous, active low; registers return to their defaults,
//   state (last input, output, velocity) clears to zero.
// ----------------------------------------------------------------------------
module position_velocity_accel_limiter
  import pval_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] commanded_position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] limited_position
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Sequencer states: one per product-quotient, plus idle and hand-off
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INV  = 4'd1;   // command velocity
  localparam logic [3:0] S_STEP = 4'd2;   // accel step per tick
  localparam logic [3:0] S_MINO = 4'd3;   // lowest reachable position
  localparam logic [3:0] S_MAXO = 4'd4;   // highest reachable position
  localparam logic [3:0] S_VEL  = 4'd5;   // velocity when following
  localparam logic [3:0] S_T1   = 4'd6;   // |D|*t/2
  localparam logic [3:0] S_T2   = 4'd7;   // D*D/(2*accel)
  localparam logic [3:0] S_DP   = 4'd8;   // 4*D*t
  localparam logic [3:0] S_FIN  = 4'd9;   // wait for output slot

  // Shared unit phases
  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_CHK  = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_DONE = 3'd4;

  // ---------------- configuration registers ----------------
  logic [26:0]        tick_r;
  logic signed [31:0] tmin_r, tmax_r;
  logic [23:0]        vlim_r;
  logic [29:0]        alim_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= 27'd1000000;
      tmin_r <= 32'sh8000_0000;
      tmax_r <= 32'sh7fff_ffff;
      vlim_r <= 24'd10000;
      alim_r <= 30'd100000;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_TICK: tick_r <= cfg_pwdata[26:0];
        REG_TMIN: tmin_r <= cfg_pwdata;
        REG_TMAX: tmax_r <= cfg_pwdata;
        REG_VLIM: vlim_r <= cfg_pwdata[23:0];
        REG_ALIM: alim_r <= cfg_pwdata[29:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_TICK: cfg_prdata = {5'd0, tick_r};
      REG_TMIN: cfg_prdata = tmin_r;
      REG_TMAX: cfg_prdata = tmax_r;
      REG_VLIM: cfg_prdata = {8'd0, vlim_r};
      REG_ALIM: cfg_prdata = {2'd0, alim_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // Zero period or accel is treated as one
  logic [63:0] t_w, acc_w;
  logic signed [63:0] vl_w;
  assign t_w   = (tick_r == 27'd0) ? 64'd1 : 64'(tick_r);
  assign acc_w = (alim_r == 30'd0) ? 64'd1 : 64'(alim_r);
  assign vl_w  = $signed(64'(vlim_r) << FRAC_BITS);

  // ---------------- registers ----------------
  logic [3:0]         st_r, st_nxt;
  logic [2:0]         u_ph_r, u_ph_nxt;
  logic [5:0]         u_cnt_r, u_cnt_nxt;
  logic [63:0]        u_hi_r, u_hi_nxt, u_lo_r, u_lo_nxt;
  logic [63:0]        u_a_r, u_a_nxt, u_c_r, u_c_nxt;
  logic               u_neg_r, u_neg_nxt, u_ovf_r, u_ovf_nxt;

  logic signed [31:0] lin_r, lin_nxt, pin_r, pin_nxt;
  logic signed [63:0] pout_r, pout_nxt, pvel_r, pvel_nxt;
  logic signed [63:0] inv_r, inv_nxt, minv_r, minv_nxt, maxv_r, maxv_nxt;
  logic signed [63:0] mino_r, mino_nxt, maxo_r, maxo_nxt;
  logic signed [63:0] d_r, d_nxt, mag_r, mag_nxt, r6_r, r6_nxt, err_r, err_nxt;
  logic signed [63:0] lout_r, lout_nxt, vel_r, vel_nxt;
  logic               up_r, up_nxt;
  logic               ov_r, ov_nxt;
  logic [31:0]        od_r, od_nxt;

  // ---------------- combinational helpers ----------------
  logic signed [63:0] lin_q, oin_q;
  logic signed [63:0] op_a;
  logic [63:0]        op_b, op_c;
  logic [63:0]        qm;
  logic signed [63:0] res;
  logic [64:0]        m_sum, d_rem;
  logic signed [31:0] cmd_cl;
  logic signed [63:0] sum_w, minv_w, maxv_w, term_w, dp2_w, lo_cl;
  logic signed [65:0] e_a, e_b;
  logic               follow, flip, up_w;

  assign lin_q = $signed(64'(lin_r)) <<< FRAC_BITS;
  assign oin_q = $signed(64'(pin_r)) <<< FRAC_BITS;

  // Operand select for the shared unit
  always_comb begin
    op_a = mag_r;
    op_b = t_w;
    op_c = NS_PER_S;
    case (st_r)
      S_INV:  begin op_a = lin_q - oin_q; op_b = NS_PER_S; op_c = t_w; end
      S_STEP: begin op_a = $signed(acc_w << FRAC_BITS); end
      S_MINO: begin op_a = minv_r; end
      S_MAXO: begin op_a = maxv_r; end
      S_VEL:  begin op_a = lin_q - pout_r; op_b = NS_PER_S; op_c = t_w; end
      S_T1:   begin op_c = NS_PER_2S; end
      S_T2:   begin op_b = mag_r; op_c = acc_w << (FRAC_BITS + 1); end
      S_DP:   begin op_a = d_r; op_c = NS_PER_QS; end
      default: ;
    endcase
  end

  // Quotient clipped to +-2^62, sign restored
  assign qm  = (u_ovf_r || u_lo_r > SAT_LIM) ? SAT_LIM : u_lo_r;
  assign res = u_neg_r ? -$signed(qm) : $signed(qm);

  assign m_sum = {1'b0, u_hi_r} + (u_lo_r[0] ? {1'b0, u_a_r} : 65'd0);
  assign d_rem = {u_hi_r, u_lo_r[63]};

  always_comb begin
    cmd_cl = $signed(in_tdata);
    if (cmd_cl < tmin_r) cmd_cl = tmin_r;
    if (cmd_cl > tmax_r) cmd_cl = tmax_r;
  end

  assign sum_w  = sat64(66'(pout_r) + 66'(res));
  assign minv_w = (pvel_r - res < -vl_w) ? -vl_w : pvel_r - res;
  assign maxv_w = (pvel_r + res > vl_w) ? vl_w : pvel_r + res;
  assign follow = (lin_q >= mino_r) && (lin_q <= sum_w) &&
                  (inv_r >= minv_r) && (inv_r <= maxv_r);
  assign term_w = sat64(66'(r6_r) - 66'(res));
  assign dp2_w  = -res;
  assign e_a    = 66'(err_r) + 66'(dp2_w);
  assign e_b    = 66'(err_r);
  assign flip   = ((e_a < 0) ? -e_a : e_a) < ((e_b < 0) ? -e_b : e_b);
  assign up_w   = up_r ^ flip;
  assign lo_cl  = (lout_r < POS_MIN) ? POS_MIN : ((lout_r > POS_MAX) ? POS_MAX : lout_r);

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // ---------------- next state ----------------
  always_comb begin
    st_nxt = st_r;   u_ph_nxt = u_ph_r; u_cnt_nxt = u_cnt_r;
    u_hi_nxt = u_hi_r; u_lo_nxt = u_lo_r; u_a_nxt = u_a_r; u_c_nxt = u_c_r;
    u_neg_nxt = u_neg_r; u_ovf_nxt = u_ovf_r;
    lin_nxt = lin_r; pin_nxt = pin_r; pout_nxt = pout_r; pvel_nxt = pvel_r;
    inv_nxt = inv_r; minv_nxt = minv_r; maxv_nxt = maxv_r;
    mino_nxt = mino_r; maxo_nxt = maxo_r; d_nxt = d_r; mag_nxt = mag_r;
    r6_nxt = r6_r; err_nxt = err_r; lout_nxt = lout_r; vel_nxt = vel_r;
    up_nxt = up_r; ov_nxt = ov_r; od_nxt = od_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    // shared multiply then divide unit
    case (u_ph_r)
      U_MUL: begin
        u_hi_nxt  = m_sum[64:1];
        u_lo_nxt  = {m_sum[0], u_lo_r[63:1]};
        u_cnt_nxt = u_cnt_r + 6'd1;
        if (u_cnt_r == 6'd63) u_ph_nxt = U_CHK;
      end
      U_CHK: begin
        u_ovf_nxt = (u_hi_r >= u_c_r);
        u_ph_nxt  = U_DIV;
      end
      U_DIV: begin
        if (d_rem >= {1'b0, u_c_r}) begin
          u_hi_nxt = 64'(d_rem - {1'b0, u_c_r});
          u_lo_nxt = {u_lo_r[62:0], 1'b1};
        end else begin
          u_hi_nxt = d_rem[63:0];
          u_lo_nxt = {u_lo_r[62:0], 1'b0};
        end
        u_cnt_nxt = u_cnt_r + 6'd1;
        if (u_cnt_r == 6'd63) u_ph_nxt = U_DONE;
      end
      default: ;
    endcase

    // launch an operation in any compute state while the unit is idle
    if (u_ph_r == U_IDLE && st_r != S_IDLE && st_r != S_FIN) begin
      u_neg_nxt = (op_a < 0) != ($signed(op_b) < 0);
      u_a_nxt   = (op_a < 0) ? 64'(-op_a) : 64'(op_a);
      u_lo_nxt  = op_b;
      u_hi_nxt  = 64'd0;
      u_c_nxt   = op_c;
      u_cnt_nxt = 6'd0;
      u_ph_nxt  = U_MUL;
    end

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          lin_nxt = cmd_cl;
          st_nxt  = S_INV;
        end
      end
      S_INV: begin
        if (u_ph_r == U_DONE) begin
          inv_nxt = res; u_ph_nxt = U_IDLE; st_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (u_ph_r == U_DONE) begin
          minv_nxt = minv_w; maxv_nxt = maxv_w;
          u_ph_nxt = U_IDLE; st_nxt = S_MINO;
        end
      end
      S_MINO: begin
        if (u_ph_r == U_DONE) begin
          mino_nxt = sum_w; u_ph_nxt = U_IDLE; st_nxt = S_MAXO;
        end
      end
      S_MAXO: begin
        if (u_ph_r == U_DONE) begin
          maxo_nxt = sum_w;
          u_ph_nxt = U_IDLE;
          // follow exactly when inside the window, else plan a ramp
          d_nxt   = sat64(66'(inv_r) - 66'(pvel_r));
          mag_nxt = (sat64(66'(inv_r) - 66'(pvel_r)) < 0) ?
                    -sat64(66'(inv_r) - 66'(pvel_r)) : sat64(66'(inv_r) - 66'(pvel_r));
          up_nxt  = (inv_r > pvel_r);
          st_nxt  = follow ? S_VEL : S_T1;
        end
      end
      S_VEL: begin
        if (u_ph_r == U_DONE) begin
          lout_nxt = lin_q; vel_nxt = res;
          u_ph_nxt = U_IDLE; st_nxt = S_FIN;
        end
      end
      S_T1: begin
        if (u_ph_r == U_DONE) begin
          r6_nxt = res; u_ph_nxt = U_IDLE; st_nxt = S_T2;
        end
      end
      S_T2: begin
        if (u_ph_r == U_DONE) begin
          err_nxt  = sat64(66'(pout_r) - 66'(oin_q) +
                           (up_r ? 66'(term_w) : -66'(term_w)));
          u_ph_nxt = U_IDLE; st_nxt = S_DP;
        end
      end
      S_DP: begin
        if (u_ph_r == U_DONE) begin
          lout_nxt = up_w ? maxo_r : mino_r;
          vel_nxt  = up_w ? maxv_r : minv_r;
          u_ph_nxt = U_IDLE; st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output slot is free, then commit state
        if (!ov_r || out_tready) begin
          pout_nxt = lo_cl;
          pvel_nxt = vel_r;
          pin_nxt  = lin_r;
          od_nxt   = (lo_cl < 0) ? 32'((lo_cl + ONE_M1) >>> FRAC_BITS)
                                 : 32'(lo_cl >>> FRAC_BITS);
          ov_nxt   = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      u_ph_r <= U_IDLE;
      ov_r   <= 1'b0;
      pin_r  <= '0;
      pout_r <= '0;
      pvel_r <= '0;
    end else begin
      st_r   <= st_nxt;
      u_ph_r <= u_ph_nxt;
      ov_r   <= ov_nxt;
      pin_r  <= pin_nxt;
      pout_r <= pout_nxt;
      pvel_r <= pvel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_cnt_r <= u_cnt_nxt; u_hi_r <= u_hi_nxt; u_lo_r <= u_lo_nxt;
    u_a_r <= u_a_nxt; u_c_r <= u_c_nxt; u_neg_r <= u_neg_nxt; u_ovf_r <= u_ovf_nxt;
    lin_r <= lin_nxt; inv_r <= inv_nxt; minv_r <= minv_nxt; maxv_r <= maxv_nxt;
    mino_r <= mino_nxt; maxo_r <= maxo_nxt; d_r <= d_nxt; mag_r <= mag_nxt;
    r6_r <= r6_nxt; err_r <= err_nxt; lout_r <= lout_nxt; vel_r <= vel_nxt;
    up_r <= up_nxt; od_r <= od_nxt;
  end

endmodule

>>> rtl/pval_chk.sv
// ----------------------------------------------------------------------------
// pval_chk
// Port-level checks for the limiter, bound to the top level.
// ----------------------------------------------------------------------------
module pval_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);

  // one item at a time: busy right after a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // a result needs work on the shared unit: no output right after an input beat
  a_nofast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled beat changed");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind position_velocity_accel_limiter pval_chk u_pval_chk (.*);

>>> tb/tb_position_velocity_accel_limiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_position_velocity_accel_limiter
// Self-checking bench for the position/velocity/acceleration limiter: drives
// position commands with bursty gaps, stalls the result side, predicts every
// limited position in Q.16 and compares beat by beat.
// ----------------------------------------------------------------------------
module tb_position_velocity_accel_limiter;
  import pval_pkg::*;

  localparam longint SATL = 64'sh4000_0000_0000_0000;
  localparam longint NSEC = 64'sd1000000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;      // [31:0] commanded_position
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] limited_position
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  position_velocity_accel_limiter i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the registers and of the motion state
  longint tick_ns, tmin, tmax, vlim, alim;
  longint last_cmd, last_pos, last_vel;

  logic [31:0] pos_expected_q[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          ramp_count = 0;
  bit          stall_enable = 1'b1;

  // Exact trunc(a*b/c) on 128-bit intermediates, saturated to +-2^62
  function automatic longint scale_div(longint a, longint b, longint c);
    logic [127:0] prod;
    logic [127:0] quo;
    longint       ua, ub;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (c == 0) c = 1;
    prod = 128'(ua) * 128'(ub);
    quo = prod / 128'(c);
    if (quo > 128'(SATL)) quo = 128'(SATL);
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint clip62(longint x);
    if (x > SATL) return SATL;
    if (x < -SATL) return -SATL;
    return x;
  endfunction

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Advance the shadow state by one command and return the limited position
  function automatic logic [31:0] shape_position(logic [31:0] cmd);
    longint one, t, acc, cin, cin_q, oin_q, in_v, step, vl;
    longint min_v, max_v, min_out, max_out, lout, vel, d, m, term, err, dp2;
    bit     up;
    one = 64'sd1 <<< FRAC_BITS;
    t = (tick_ns != 0) ? tick_ns : 1;
    acc = (alim != 0) ? alim : 1;
    cin = longint'($signed(cmd));
    if (cin < tmin) cin = tmin;
    if (cin > tmax) cin = tmax;
    cin_q = cin * one;
    oin_q = last_cmd * one;
    in_v = scale_div(cin_q - oin_q, NSEC, t);
    step = scale_div(acc * one, t, NSEC);
    vl = vlim * one;
    min_v = last_vel - step;
    if (min_v < -vl) min_v = -vl;
    max_v = last_vel + step;
    if (max_v > vl) max_v = vl;
    min_out = clip62(last_pos + scale_div(min_v, t, NSEC));
    max_out = clip62(last_pos + scale_div(max_v, t, NSEC));
    if (cin_q >= min_out && cin_q <= max_out && in_v >= min_v && in_v <= max_v) begin
      lout = cin_q;
      vel = scale_div(cin_q - last_pos, NSEC, t);
    end else begin
      ramp_count++;
      up = in_v > last_vel;
      d = clip62(in_v - last_vel);
      m = mag(d);
      term = clip62(scale_div(m, t, 2 * NSEC) - scale_div(m, m, (acc <<< FRAC_BITS) * 2));
      if (!up) term = -term;
      err = clip62(last_pos - oin_q + term);
      dp2 = -scale_div(d, t, NSEC / 4);
      if (mag(err + dp2) < mag(err)) up = !up;
      lout = up ? max_out : min_out;
      vel = up ? max_v : min_v;
    end
    if (lout < POS_MIN) lout = POS_MIN;
    if (lout > POS_MAX) lout = POS_MAX;
    last_pos = lout;
    last_vel = vel;
    last_cmd = cin;
    return 32'(lout / one);
  endfunction

  // Send one command beat; hold valid until the block takes it
  task automatic send_command(logic [31:0] cmd);
    in_tvalid <= 1'b1;
    in_tdata <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pos_expected_q.push_back(shape_position(cmd));
    beats_sent++;
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Bursty sender: random burst lengths with random gaps in between
  int burst_left = 0;
  task automatic send_paced(logic [31:0] cmd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 200)) @(posedge clk);
    end
    burst_left--;
    send_command(cmd);
  endtask

  // Wait until every expected beat has come back, with a guard against a hang
  task automatic drain;
    int guard;
    guard = 0;
    while (pos_expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TICK: tick_ns = longint'(value[26:0]);
      REG_TMIN: tmin = longint'($signed(value));
      REG_TMAX: tmax = longint'($signed(value));
      REG_VLIM: vlim = longint'(value[23:0]);
      default:  alim = longint'(value[29:0]);
    endcase
  endtask

  task automatic set_limits(logic [31:0] t, logic [31:0] lo, logic [31:0] hi,
                            logic [31:0] v, logic [31:0] a);
    write_reg(REG_TICK, t);
    write_reg(REG_TMIN, lo);
    write_reg(REG_TMAX, hi);
    write_reg(REG_VLIM, v);
    write_reg(REG_ALIM, a);
  endtask

  // Result checker: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    logic [31:0] exp_pos;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (pos_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: limited_position=%0d",
                                       $signed(out_tdata));
      end else begin
        exp_pos = pos_expected_q.pop_front();
        if (exp_pos !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: limited_position expected %0d actual %0d",
                     $signed(exp_pos), $signed(out_tdata));
        end
      end
    end
  end

  // Receiver stall pattern: out_tready is random, high most of the time
  always @(posedge clk) begin
    if (!stall_enable) out_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Directed: register defaults, field extremes, zero period/accel/velocity, inverted window
  task automatic test_directed;
    send_command(32'h0000_0000);
    send_command(32'h7fff_ffff);
    send_command(32'h8000_0000);
    send_command(32'h0000_0005);
    send_command(32'hffff_fffb);
    drain();
    // zero tick period and zero accel: clamped to 1
    set_limits(32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd16777215, 32'd0);
    send_command(32'd100);
    send_command(32'h7fff_ffff);
    drain();
    // zero velocity limit and inverted travel window
    set_limits(32'd1000, 32'd500, 32'hffff_fe00, 32'd0, 32'h3fff_ffff);
    send_command(32'd0);
    send_command(32'h8000_0000);
    drain();
    // huge accel with slow tick at the widest velocity limit
    set_limits(32'h07ff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffffff, 32'h3fff_ffff);
    send_command(32'h7fff_ffff);
    send_command(32'h8000_0000);
    send_command(32'h7fff_ffff);
    send_command(32'd0);
    drain();
  endtask

  // Random: well-formed trajectories under varied limits, plus noise
  task automatic test_random_motion;
    logic [31:0] pos, lo, hi;
    int          phase, k;
    for (phase = 0; phase < 10; phase++) begin
      lo = $urandom();
      hi = $urandom();
      if (phase % 3 != 2 && $signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
      set_limits($urandom_range(1000, 100000000), lo, hi,
                 (phase == 0) ? 32'd1 : $urandom_range(1, 16777215),
                 (phase == 1) ? 32'd1 : $urandom_range(1, 1073741823));
      pos = $urandom_range(0, 20000) - 10000;
      for (k = 0; k < 110; k++) begin
        if ($urandom_range(0, 9) == 0) pos = $urandom();
        else pos = pos + $urandom_range(0, 2000) - 1000;
        send_paced(pos);
      end
      drain();
    end
  endtask

  initial begin
    tick_ns = 1000000; tmin = -(64'sd1 <<< 31); tmax = (64'sd1 <<< 31) - 1;
    vlim = 10000; alim = 100000;
    last_cmd = 0; last_pos = 0; last_vel = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_motion();
    drain();
    $display("Sent %0d commands, checked %0d positions, %0d on the ramp path.",
             beats_sent, beats_checked, ramp_count);
    $display("Covered extremes, zero period/accel/velocity, inverted travel window.");
    if (mismatches == 0 && pos_expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
